/* sv/bceq_pkg.sv */
// Package for the button change event queue.
// Holds the sizes, event and command codes, the button order table and the
// controller/datapath interface types. Depends on nothing.
package bceq_pkg;

	localparam int QUEUE_DEPTH  = 16;
	localparam int BUTTON_COUNT = 10;
	localparam int ORDER_LEN    = 10;
	localparam int SCAN_COUNT   = (BUTTON_COUNT < ORDER_LEN) ? BUTTON_COUNT : ORDER_LEN;

	localparam int LEVEL_W = 10;
	localparam int INDEX_W = 4;
	localparam int KIND_W  = 2;
	localparam int PTR_W   = $clog2(QUEUE_DEPTH);

	localparam logic [INDEX_W-1:0] START_INDEX  = 4'd6;
	localparam logic [INDEX_W-1:0] SELECT_INDEX = 4'd7;
	localparam logic [INDEX_W-1:0] SCAN_LAST    = INDEX_W'(SCAN_COUNT - 1);
	localparam logic [PTR_W-1:0]   PTR_LAST     = PTR_W'(QUEUE_DEPTH - 1);

	localparam logic [KIND_W-1:0] EV_NONE    = 2'd0;
	localparam logic [KIND_W-1:0] EV_PRESS   = 2'd1;
	localparam logic [KIND_W-1:0] EV_RELEASE = 2'd2;

	localparam logic CMD_POLL = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef struct packed {
		logic                released;
		logic [INDEX_W-1:0]  index;
	} event_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN_POLL,
		ST_FIN_READ
	} state_t;

	typedef struct packed {
		logic capture_poll;
		logic issue_read;
		logic scan_step;
		logic load_poll;
		logic load_read;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_last;
	} ctrl_status_t;

	// Level bit that carries each button, in button index order.
	function automatic logic [INDEX_W-1:0] level_bit_of(input logic [INDEX_W-1:0] idx);
		logic [INDEX_W-1:0] lb;
		case (idx)
			4'd0:    lb = 4'd6;
			4'd1:    lb = 4'd7;
			4'd2:    lb = 4'd5;
			4'd3:    lb = 4'd4;
			4'd4:    lb = 4'd0;
			4'd5:    lb = 4'd1;
			4'd6:    lb = 4'd3;
			4'd7:    lb = 4'd2;
			4'd8:    lb = 4'd9;
			4'd9:    lb = 4'd8;
			default: lb = 4'd0;
		endcase
		return lb;
	endfunction

endpackage

/* sv/bceq_ctrl.sv */
// Controller state machine of the button change event queue.
// Sequences poll scans, queue reads and the output register. Uses bceq_pkg.
module bceq_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    cmd,
	input  logic                    out_ready,
	input  bceq_pkg::ctrl_status_t  status,
	output logic                    in_ready,
	output logic                    out_valid,
	output bceq_pkg::ctrl_cmd_t     ctrl
);
	import bceq_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;
	logic   out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ctrl        = '0;
		in_ready    = 1'b0;
		out_free    = !out_valid_q || out_ready;
		out_valid_d = out_valid_q && !out_ready;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (cmd == CMD_READ) begin
						ctrl.issue_read = 1'b1;
						state_d         = ST_FIN_READ;
					end else begin
						ctrl.capture_poll = 1'b1;
						state_d           = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				ctrl.scan_step = 1'b1;
				if (status.scan_last) begin
					state_d = ST_FIN_POLL;
				end
			end
			ST_FIN_POLL: begin
				if (out_free) begin
					ctrl.load_poll = 1'b1;
					out_valid_d    = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			ST_FIN_READ: begin
				if (out_free) begin
					ctrl.load_read = 1'b1;
					out_valid_d    = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

/* sv/bceq_dp.sv */
// Datapath of the button change event queue.
// Holds the level and held registers, the event ring memory with its
// pointers, and the output register. Uses bceq_pkg.
module bceq_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [bceq_pkg::LEVEL_W-1:0]    buttons,
	input  bceq_pkg::ctrl_cmd_t             ctrl,
	output bceq_pkg::ctrl_status_t          status,
	output logic [bceq_pkg::KIND_W-1:0]     event_kind,
	output logic [bceq_pkg::INDEX_W-1:0]    button_index,
	output logic [bceq_pkg::LEVEL_W-1:0]    held_mask,
	output logic                            fast_render
);
	import bceq_pkg::*;

	event_t mem [QUEUE_DEPTH];

	logic [LEVEL_W-1:0] last_q, now_q, diff_q, held_q;
	logic               render_q;
	logic [INDEX_W-1:0] scan_idx_q;
	logic [PTR_W-1:0]   wp_q, rp_q;
	logic [PTR_W-1:0]   wp_next, rp_next;
	event_t             rd_q;
	logic               rd_hit_q;

	logic [KIND_W-1:0]  kind_q;
	logic [INDEX_W-1:0] index_q;
	logic [LEVEL_W-1:0] held_out_q;
	logic               render_out_q;

	logic [INDEX_W-1:0] lb;
	logic               changed;
	logic               pressed;
	logic               full;
	logic               empty;
	logic               push;
	logic               new_select;

	always_comb begin
		lb         = level_bit_of(scan_idx_q);
		changed    = diff_q[lb];
		pressed    = now_q[lb];
		wp_next    = (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
		rp_next    = (rp_q == PTR_LAST) ? '0 : rp_q + 1'b1;
		full       = (wp_next == rp_q);
		empty      = (wp_q == rp_q);
		push       = ctrl.scan_step && changed && !full;
		new_select = buttons[level_bit_of(SELECT_INDEX)]
			&& !last_q[level_bit_of(SELECT_INDEX)];
		status.scan_last = (scan_idx_q == SCAN_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q     <= '0;
			now_q      <= '0;
			diff_q     <= '0;
			held_q     <= '0;
			render_q   <= 1'b0;
			wp_q       <= '0;
			rp_q       <= '0;
			scan_idx_q <= '0;
			rd_hit_q   <= 1'b0;
		end else begin
			if (ctrl.capture_poll) begin
				now_q      <= buttons;
				diff_q     <= buttons ^ last_q;
				last_q     <= buttons;
				scan_idx_q <= '0;
				if (new_select) begin
					render_q <= !render_q;
				end
			end
			if (ctrl.scan_step) begin
				scan_idx_q <= scan_idx_q + 1'b1;
				if (changed && scan_idx_q != START_INDEX) begin
					held_q[scan_idx_q] <= pressed;
				end
			end
			if (push) begin
				wp_q <= wp_next;
			end
			if (ctrl.issue_read) begin
				rd_hit_q <= !empty;
				if (!empty) begin
					rp_q <= rp_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= '{released: !pressed, index: scan_idx_q};
		end
		if (ctrl.issue_read) begin
			rd_q <= mem[rp_q];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_poll || ctrl.load_read) begin
			held_out_q   <= held_q;
			render_out_q <= render_q;
			if (ctrl.load_read && rd_hit_q) begin
				kind_q  <= rd_q.released ? EV_RELEASE : EV_PRESS;
				index_q <= rd_q.index;
			end else begin
				kind_q  <= EV_NONE;
				index_q <= '0;
			end
		end
	end

	assign event_kind   = kind_q;
	assign button_index = index_q;
	assign held_mask    = held_out_q;
	assign fast_render  = render_out_q;

endmodule

/* sv/button_change_event_queue.sv */
// Top level of the button change event queue.
// Joins bceq_ctrl and bceq_dp. Uses bceq_pkg.
//
// Each request on the input channel is a poll (cmd 0) with the sampled button
// levels or a read (cmd 1) that pops one queued event. Every request gives
// exactly one result: a poll returns no event and the updated held mask and
// render flag; a read returns the oldest press or release event, or no event
// when the queue is empty. The queue keeps at most fifteen events and drops
// new ones when full.
// A poll scans the buttons one per cycle and then loads its result into the
// output register; a read fetches the oldest entry through the registered
// memory read and then loads the output register. The next request is
// taken once the controller is back in idle.
// A new request is accepted only when the previous one has
// finished its work; the output register lets it be taken while a result
// still waits, and a stalled receiver holds the finished work until the
// output register is free. Reset clears the levels, held mask, render flag,
// pointers and output valid; queue entries are not cleared.
module button_change_event_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            cmd,
	input  logic [bceq_pkg::LEVEL_W-1:0]    buttons,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [bceq_pkg::KIND_W-1:0]     event_kind,
	output logic [bceq_pkg::INDEX_W-1:0]    button_index,
	output logic [bceq_pkg::LEVEL_W-1:0]    held_mask,
	output logic                            fast_render
);
	import bceq_pkg::*;

	ctrl_cmd_t    ctrl;
	ctrl_status_t status;

	bceq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cmd       (cmd),
		.out_ready (out_ready),
		.status    (status),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.ctrl      (ctrl)
	);

	bceq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.buttons      (buttons),
		.ctrl         (ctrl),
		.status       (status),
		.event_kind   (event_kind),
		.button_index (button_index),
		.held_mask    (held_mask),
		.fast_render  (fast_render)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while the previous one was still in work");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (event_kind == EV_NONE || event_kind == EV_PRESS
			|| event_kind == EV_RELEASE))
		else $error("illegal event kind on the output");

	a_no_start_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !held_mask[START_INDEX])
		else $error("start button shows as held");

	a_none_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == EV_NONE |-> button_index == '0)
		else $error("button index set on a result with no event");

endmodule
